/* hdl/gcr62_pkg.sv */
// Shared constants, types and the nibble translation function for the 6-and-2 GCR decoder.
package gcr62_pkg;

  localparam int unsigned AuxCount      = 86;
  localparam int unsigned DataCount     = 256;
  localparam int unsigned SectorNibbles = AuxCount + DataCount + 1;

  localparam int unsigned PosW  = $clog2(SectorNibbles);
  localparam int unsigned SlotW = $clog2(AuxCount);
  localparam int unsigned GrpW  = 2;

  localparam logic [PosW-1:0]  PosFirstData = PosW'(AuxCount);
  localparam logic [PosW-1:0]  PosChecksum  = PosW'(AuxCount + DataCount);
  localparam logic [SlotW-1:0] SlotLast     = SlotW'(AuxCount - 1);

  typedef logic [5:0] code6_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [GrpW-1:0] grp_t;

  // Six-and-two write table; the decoder searches it for a matching code.
  localparam logic [7:0] WriteCode [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // Inverse translation. Codes in the table are unique, so the matches are
  // mutually exclusive; a nibble outside the table decodes to zero.
  function automatic code6_t gcr_decode(input logic [7:0] nib);
    code6_t res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      if (WriteCode[i] == nib) begin
        res = code6_t'(i);
      end
    end
    return res;
  endfunction

endpackage

/* hdl/gcr_six_and_two_sector_decoder_unit.sv */
// Top level of the 6-and-2 GCR sector decoder: translation, checksum chain and aux store.
//
// Usage: the input stream carries one raw disk nibble per word on s_tdata.
// A sector is exactly 343 words: 86 auxiliary nibbles, 256 data nibbles and
// one checksum nibble; there is no resynchronization, so the caller must
// align the stream to a sector start. The auxiliary nibbles produce no
// output word. Each data nibble produces one output word with the decoded
// byte and its index 0..255, and the checksum nibble produces one status
// word, marked by m_tlast, whose checksum_ok bit tells whether the chained
// checksum matched.
// An accepted word that yields output is presented on the output channel
// in the next cycle. Throughput is one nibble per cycle while the receiver
// does not stall; the single-port-per-cycle aux store is read or written at
// most once per nibble, and its read register is the output pipeline stage.
// Reset clears the position, the checksum chain and the output valid. The
// aux store is not cleared; every entry is written before it is read.
// When the receiver stalls with a word pending, s_tready drops in the same
// cycle and nothing is lost; aux nibbles still need the output stage free.
module gcr_six_and_two_sector_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] nibble
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index, [16] checksum_ok
  output logic        m_tlast    // is_status: final checksum status word of the sector
);
  import gcr62_pkg::*;

  // Input-side state.
  pos_t   pos;
  slot_t  slot;
  grp_t   grp;
  code6_t running_check;

  // Output stage.
  logic       s1_valid;
  logic       s1_last;
  logic       s1_ok;
  code6_t     s1_code;
  grp_t       s1_grp;
  logic [7:0] s1_index;

  // Aux store: 86 entries of packed bit-swapped pairs.
  code6_t store [AuxCount];
  code6_t rd_q;

  logic   s_fire;
  logic   is_aux;
  logic   is_sum;
  code6_t code;
  code6_t chained;
  pos_t   data_k;
  logic [1:0] pair;

  assign s_tready = !s1_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign is_aux   = pos < PosFirstData;
  assign is_sum   = pos == PosChecksum;
  assign code     = gcr_decode(s_tdata);
  assign chained  = running_check ^ code;
  assign data_k   = pos - PosFirstData;

  // Position, slot/group counters and the checksum chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      slot          <= '0;
      grp           <= '0;
      running_check <= '0;
    end else if (s_fire) begin
      if (is_sum) begin
        pos           <= '0;
        slot          <= '0;
        grp           <= '0;
        running_check <= '0;
      end else begin
        pos           <= pos + pos_t'(1);
        running_check <= chained;
        if (slot == SlotLast) begin
          slot <= '0;
          if (!is_aux) begin
            grp <= grp + grp_t'(1);
          end
        end else begin
          slot <= slot + slot_t'(1);
        end
      end
    end
  end

  // Store: aux nibbles write their entry, data nibbles read the matching one.
  // Writes and reads of one sector never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (s_fire && is_aux) begin
      store[slot] <= chained;
    end
    if (s_fire && !is_aux && !is_sum) begin
      rd_q <= store[slot];
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_fire && !is_aux;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && !is_aux) begin
      s1_last  <= is_sum;
      s1_ok    <= is_sum && (running_check == code);
      s1_code  <= chained;
      s1_grp   <= grp;
      s1_index <= is_sum ? 8'h00 : data_k[7:0];
    end
  end

  always_comb begin
    case (s1_grp)
      2'd0:    pair = rd_q[1:0];
      2'd1:    pair = rd_q[3:2];
      2'd2:    pair = rd_q[5:4];
      default: pair = 2'b00;
    endcase
  end

  assign m_tvalid = s1_valid;
  assign m_tlast  = s1_last;
  assign m_tdata  = {7'd0, s1_ok, s1_index,
                     s1_last ? 8'h00 : {s1_code, pair[0], pair[1]}};

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PosChecksum)
    else $error("sector position out of range");

  a_slot_tracks_pos: assert property (@(posedge clk) disable iff (rst)
    (!is_aux && !is_sum) |->
      (PosW'(grp) * PosW'(AuxCount) + PosW'(slot)) == data_k)
    else $error("slot and group disagree with position");

  a_sum_restarts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_sum) |=> (pos == '0 && running_check == '0 && m_tvalid && m_tlast))
    else $error("checksum nibble did not restart the sector");

  a_first_data: assert property (@(posedge clk) disable iff (rst)
    (s_fire && pos == PosFirstData) |=> (m_tvalid && !m_tlast && m_tdata[15:8] == 8'h00))
    else $error("first data word not at index zero");

  a_aux_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_aux) |=> !m_tvalid)
    else $error("aux nibble produced an output word");
`endif

endmodule
